// ===== hw/rtl/small_isa_instruction_execute_core_assert.svh =====
// Assertion macros for the instruction execute core.
// Expects signals named clock and reset in the module that uses them.
`ifndef SMALL_ISA_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define SMALL_ISA_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`ifndef SYNTH
`define SIE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SIE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SIE_ASSERT_IMP(label, ante, cons, msg)
`define SIE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sie_pkg.sv =====
// Shared constants, opcodes and types of the instruction execute core.
// No dependencies.
package sie_pkg;
   localparam int unsigned MEM_DEPTH_DEF = 1024;
   localparam int unsigned NUM_REGS      = 16;
   localparam int unsigned OPC_W         = 3;
   localparam int unsigned REG_IDX_W     = 4;
   localparam int unsigned IMM_W         = 20;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned MEM_ADDR_W    = 10;

   localparam logic [OPC_W-1:0] OPC_ADD  = 3'd0;
   localparam logic [OPC_W-1:0] OPC_NAND = 3'd1;
   localparam logic [OPC_W-1:0] OPC_ADDI = 3'd2;
   localparam logic [OPC_W-1:0] OPC_LW   = 3'd3;
   localparam logic [OPC_W-1:0] OPC_SW   = 3'd4;
   localparam logic [OPC_W-1:0] OPC_BEQ  = 3'd5;
   localparam logic [OPC_W-1:0] OPC_JALR = 3'd6;

   typedef logic [WORD_W-1:0] word_type;

   // stage load enables handed to the address wrap unit
   typedef struct packed {
      logic to_s2;
      logic to_s3;
   } sie_adv_type;
endpackage

// ===== hw/rtl/sie_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module sie_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/sie_wrap.sv =====
// Two-stage reduction of a 32-bit data address modulo the memory depth.
// Reciprocal multiply, back-multiply, one correcting subtract. Uses sie_pkg.
module sie_wrap #(
   parameter int unsigned MEM_DEPTH = sie_pkg::MEM_DEPTH_DEF
) (
   input  logic                         clock,
   input  sie_pkg::sie_adv_type         adv,
   input  sie_pkg::word_type            sum,
   output logic [$clog2(MEM_DEPTH)-1:0] addr
);
   import sie_pkg::*;

   localparam int unsigned AW         = $clog2(MEM_DEPTH);
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(MEM_DEPTH);
   localparam word_type    RECIP      = RECIP_WIDE[WORD_W-1:0];
   localparam word_type    DEPTH_W    = WORD_W'(MEM_DEPTH);
   localparam logic [AW:0] DEPTH_X    = (AW+1)'(MEM_DEPTH);

   word_type          s2_sum_ff;
   word_type          s3_sum_ff;
   word_type          s3_quot_ff;
   logic [63:0]       recip_prod;
   word_type          back_prod;
   word_type          rem_full;
   logic [AW:0]       rem;

   // quotient estimate is exact or one low
   assign recip_prod = 64'(s2_sum_ff) * 64'(RECIP);

   always_ff @(posedge clock) begin
      if (adv.to_s2) begin
         s2_sum_ff <= sum;
      end
      if (adv.to_s3) begin
         s3_sum_ff  <= s2_sum_ff;
         s3_quot_ff <= recip_prod[63:32];
      end
   end

   assign back_prod = s3_quot_ff * DEPTH_W;
   assign rem_full  = s3_sum_ff - back_prod;
   assign rem       = rem_full[AW:0];
   assign addr      = (rem >= DEPTH_X) ? AW'(rem - DEPTH_X) : rem[AW-1:0];
endmodule

// ===== hw/rtl/small_isa_instruction_execute_core.sv =====
// Instruction execute core: execute, address wrap (2 stages), memory, writeback, output reg.
// One instruction per cycle sustained unless a load hazard or rsp_stall holds the pipeline.
// An instruction that reads a register loaded by one of the two loads just ahead of it
// waits in execute until the load data leaves the data memory read port.
// Reset clears the register file valid bits and PC at once; the data memory is zeroed by a
// sweep over all MEM_DEPTH words, during which req_stall stays high.
`include "small_isa_instruction_execute_core_assert.svh"
module small_isa_instruction_execute_core #(
   parameter int unsigned MEM_DEPTH = sie_pkg::MEM_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sie_pkg::OPC_W-1:0]            req_opcode,
   input  logic [sie_pkg::REG_IDX_W-1:0]        req_reg_x,
   input  logic [sie_pkg::REG_IDX_W-1:0]        req_reg_y,
   input  logic [sie_pkg::REG_IDX_W-1:0]        req_reg_z,
   input  logic signed [sie_pkg::IMM_W-1:0]     req_imm,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sie_pkg::WORD_W-1:0]           rsp_next_pc,
   output logic                                 rsp_branch_taken,
   output logic                                 rsp_reg_write,
   output logic [sie_pkg::REG_IDX_W-1:0]        rsp_written_index,
   output logic signed [sie_pkg::WORD_W-1:0]    rsp_written_value,
   output logic                                 rsp_mem_write,
   output logic [sie_pkg::MEM_ADDR_W-1:0]       rsp_mem_address,
   output logic signed [sie_pkg::WORD_W-1:0]    rsp_mem_data
);
   import sie_pkg::*;

   localparam int unsigned AW      = $clog2(MEM_DEPTH);
   localparam int unsigned NUM_OPD = 3;
   localparam int unsigned OPD_X   = 0;
   localparam int unsigned OPD_Y   = 1;
   localparam int unsigned OPD_Z   = 2;

   typedef struct packed {
      word_type               next_pc;
      logic                   taken;
      logic                   reg_wr;
      logic                   is_ld;
      logic                   mem_wr;
      logic [REG_IDX_W-1:0]   idx;
      word_type               val;
      word_type               mem_data;
   } stage_type;

   typedef struct packed {
      word_type               next_pc;
      logic                   taken;
      logic                   reg_wr;
      logic [REG_IDX_W-1:0]   idx;
      word_type               val;
      logic                   mem_wr;
      logic [MEM_ADDR_W-1:0]  mem_addr;
      word_type               mem_data;
   } rsp_type;

   // handshake and stage control
   logic req_accept;
   logic out_free;
   logic s1_adv, s2_adv, s3_adv, s4_adv;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in, s4_v_in, rsp_v_in;
   logic s1_hazard;
   sie_adv_type wrap_adv;

   // execute stage
   logic [REG_IDX_W-1:0]   req_idx   [NUM_OPD];
   logic [REG_IDX_W-1:0]   s1_idx_ff [NUM_OPD];
   logic                   s1_vld_ff [NUM_OPD];
   word_type               s1_opd_ff [NUM_OPD];
   word_type               opd       [NUM_OPD];
   word_type               rf_rd     [NUM_OPD];
   logic                   use_opd   [NUM_OPD];
   logic                   s1_fresh_ff;
   logic [OPC_W-1:0]       s1_op_ff;
   logic signed [IMM_W-1:0] s1_imm_ff;
   word_type               pc_ff;
   word_type               pc_inc;
   word_type               imm_ext;
   word_type               addr_sum;
   stage_type              s1_res;

   // later stages
   stage_type              s2_ff, s3_ff, s4_ff;
   logic [AW-1:0]          wrap_addr;
   logic [AW-1:0]          s4_addr_ff;
   word_type               dm_rd;
   word_type               s4_val;
   word_type               s4_mem_data;
   logic                   commit;
   rsp_type                rsp_ff;

   // register file valid bits and the most recent committed write
   logic [NUM_REGS-1:0]    reg_valid_ff;
   logic                   cw_v_ff;
   logic [REG_IDX_W-1:0]   cw_idx_ff;
   word_type               cw_val_ff;

   // data memory clearing sweep
   logic                   clr_busy_ff;
   logic [AW-1:0]          clr_addr_ff;

   logic                   dm_wr_en;
   logic [AW-1:0]          dm_wr_addr;
   word_type               dm_wr_data;
   logic                   dm_rd_en;

   assign req_idx[OPD_X] = req_reg_x;
   assign req_idx[OPD_Y] = req_reg_y;
   assign req_idx[OPD_Z] = req_reg_z;

   // ---------------- stage control ----------------
   assign out_free   = !rsp_v_ff || !rsp_stall;
   assign s4_adv     = s4_v_ff && out_free;
   assign s3_adv     = s3_v_ff && (!s4_v_ff || s4_adv);
   assign s2_adv     = s2_v_ff && (!s3_v_ff || s3_adv);
   assign s1_adv     = s1_v_ff && !s1_hazard && (!s2_v_ff || s2_adv);
   assign req_stall  = clr_busy_ff || (s1_v_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   assign s1_v_in  = req_accept || (s1_v_ff && !s1_adv);
   assign s2_v_in  = s1_adv || (s2_v_ff && !s2_adv);
   assign s3_v_in  = s2_adv || (s3_v_ff && !s3_adv);
   assign s4_v_in  = s3_adv || (s4_v_ff && !s4_adv);
   assign rsp_v_in = s4_adv || (rsp_v_ff && rsp_stall);

   assign wrap_adv.to_s2 = s1_adv;
   assign wrap_adv.to_s3 = s2_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
         rsp_v_ff    <= 1'b0;
         s1_fresh_ff <= 1'b0;
         pc_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         s1_v_ff     <= s1_v_in;
         s2_v_ff     <= s2_v_in;
         s3_v_ff     <= s3_v_in;
         s4_v_ff     <= s4_v_in;
         rsp_v_ff    <= rsp_v_in;
         s1_fresh_ff <= req_accept;
         if (s1_adv) begin
            pc_ff <= s1_res.next_pc;
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MEM_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   // ---------------- register file ----------------
   for (genvar k = 0; k < NUM_OPD; k++) begin : g_rf
      sie_ram #(
         .WIDTH (WORD_W),
         .DEPTH (NUM_REGS)
      ) u_rf (
         .clock   (clock),
         .wr_en   (commit),
         .wr_addr (s4_ff.idx),
         .wr_data (s4_val),
         .rd_en   (req_accept),
         .rd_addr (req_idx[k]),
         .rd_data (rf_rd[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
         cw_v_ff      <= 1'b0;
      end else if (commit) begin
         reg_valid_ff[s4_ff.idx] <= 1'b1;
         cw_v_ff                 <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         cw_idx_ff <= s4_ff.idx;
         cw_val_ff <= s4_val;
      end
   end

   // ---------------- execute stage ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff  <= req_opcode;
         s1_imm_ff <= req_imm;
      end
      for (int k = 0; k < NUM_OPD; k++) begin
         if (req_accept) begin
            s1_idx_ff[k] <= req_idx[k];
            s1_vld_ff[k] <= reg_valid_ff[req_idx[k]];
         end
         // keep the resolved operand so writes committed while waiting are not lost
         s1_opd_ff[k] <= opd[k];
      end
   end

   // operand resolution, newest in-flight write first
   always_comb begin
      for (int k = 0; k < NUM_OPD; k++) begin
         if (s1_fresh_ff) begin
            opd[k] = s1_vld_ff[k] ? rf_rd[k] : '0;
         end else begin
            opd[k] = s1_opd_ff[k];
         end
         if (cw_v_ff && cw_idx_ff == s1_idx_ff[k]) begin
            opd[k] = cw_val_ff;
         end
         if (s4_v_ff && s4_ff.reg_wr && s4_ff.idx == s1_idx_ff[k]) begin
            opd[k] = s4_val;
         end
         if (s3_v_ff && s3_ff.reg_wr && s3_ff.idx == s1_idx_ff[k]) begin
            opd[k] = s3_ff.val;
         end
         if (s2_v_ff && s2_ff.reg_wr && s2_ff.idx == s1_idx_ff[k]) begin
            opd[k] = s2_ff.val;
         end
      end
   end

   // which register fields each opcode really reads
   always_comb begin
      use_opd[OPD_X] = 1'b0;
      use_opd[OPD_Y] = 1'b0;
      use_opd[OPD_Z] = 1'b0;
      unique case (s1_op_ff) inside
         OPC_ADD, OPC_NAND: begin
            use_opd[OPD_Y] = 1'b1;
            use_opd[OPD_Z] = 1'b1;
         end
         OPC_ADDI, OPC_LW: begin
            use_opd[OPD_Y] = 1'b1;
         end
         OPC_SW, OPC_BEQ: begin
            use_opd[OPD_X] = 1'b1;
            use_opd[OPD_Y] = 1'b1;
         end
         OPC_JALR: begin
            use_opd[OPD_X] = (s1_idx_ff[OPD_X] != s1_idx_ff[OPD_Y]);
         end
         default: begin
         end
      endcase
   end

   // load data is not there before the memory stage has read it
   always_comb begin
      s1_hazard = 1'b0;
      for (int k = 0; k < NUM_OPD; k++) begin
         if (use_opd[k] &&
             ((s2_v_ff && s2_ff.is_ld && s2_ff.idx == s1_idx_ff[k]) ||
              (s3_v_ff && s3_ff.is_ld && s3_ff.idx == s1_idx_ff[k]))) begin
            s1_hazard = 1'b1;
         end
      end
   end

   assign pc_inc   = pc_ff + WORD_W'(1);
   assign imm_ext  = WORD_W'(s1_imm_ff);
   assign addr_sum = opd[OPD_Y] + imm_ext;

   always_comb begin
      s1_res          = '0;
      s1_res.next_pc  = pc_inc;
      unique case (s1_op_ff)
         OPC_ADD: begin
            s1_res.reg_wr = 1'b1;
            s1_res.idx    = s1_idx_ff[OPD_X];
            s1_res.val    = opd[OPD_Y] + opd[OPD_Z];
         end
         OPC_NAND: begin
            s1_res.reg_wr = 1'b1;
            s1_res.idx    = s1_idx_ff[OPD_X];
            s1_res.val    = ~(opd[OPD_Y] & opd[OPD_Z]);
         end
         OPC_ADDI: begin
            s1_res.reg_wr = 1'b1;
            s1_res.idx    = s1_idx_ff[OPD_X];
            s1_res.val    = addr_sum;
         end
         OPC_LW: begin
            s1_res.reg_wr = 1'b1;
            s1_res.is_ld  = 1'b1;
            s1_res.idx    = s1_idx_ff[OPD_X];
         end
         OPC_SW: begin
            s1_res.mem_wr   = 1'b1;
            s1_res.mem_data = opd[OPD_X];
         end
         OPC_BEQ: begin
            if (opd[OPD_X] == opd[OPD_Y]) begin
               s1_res.taken   = 1'b1;
               s1_res.next_pc = pc_inc + imm_ext;
            end
         end
         OPC_JALR: begin
            s1_res.reg_wr  = 1'b1;
            s1_res.taken   = 1'b1;
            s1_res.idx     = s1_idx_ff[OPD_Y];
            s1_res.val     = pc_inc;
            // link is written before the target is read
            s1_res.next_pc = (s1_idx_ff[OPD_X] == s1_idx_ff[OPD_Y]) ? pc_inc : opd[OPD_X];
         end
         default: begin
         end
      endcase
   end

   // ---------------- address wrap, memory, writeback ----------------
   sie_wrap #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_wrap (
      .clock (clock),
      .adv   (wrap_adv),
      .sum   (addr_sum),
      .addr  (wrap_addr)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_ff <= s1_res;
      end
      if (s2_adv) begin
         s3_ff <= s2_ff;
      end
      if (s3_adv) begin
         s4_ff      <= s3_ff;
         s4_addr_ff <= wrap_addr;
      end
   end

   assign dm_wr_en   = clr_busy_ff || (s3_adv && s3_ff.mem_wr);
   assign dm_wr_addr = clr_busy_ff ? clr_addr_ff : wrap_addr;
   assign dm_wr_data = clr_busy_ff ? '0 : s3_ff.mem_data;
   assign dm_rd_en   = s3_adv && s3_ff.is_ld;

   sie_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_DEPTH)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data),
      .rd_en   (dm_rd_en),
      .rd_addr (wrap_addr),
      .rd_data (dm_rd)
   );

   assign s4_val      = s4_ff.is_ld ? dm_rd : s4_ff.val;
   assign s4_mem_data = s4_ff.is_ld ? dm_rd : s4_ff.mem_data;
   assign commit      = s4_adv && s4_ff.reg_wr;

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         rsp_ff.next_pc  <= s4_ff.next_pc;
         rsp_ff.taken    <= s4_ff.taken;
         rsp_ff.reg_wr   <= s4_ff.reg_wr;
         rsp_ff.idx      <= s4_ff.idx;
         rsp_ff.val      <= s4_val;
         rsp_ff.mem_wr   <= s4_ff.mem_wr;
         rsp_ff.mem_addr <= (s4_ff.is_ld || s4_ff.mem_wr) ? MEM_ADDR_W'(s4_addr_ff) : '0;
         rsp_ff.mem_data <= s4_mem_data;
      end
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_next_pc       = rsp_ff.next_pc;
   assign rsp_branch_taken  = rsp_ff.taken;
   assign rsp_reg_write     = rsp_ff.reg_wr;
   assign rsp_written_index = rsp_ff.idx;
   assign rsp_written_value = $signed(rsp_ff.val);
   assign rsp_mem_write     = rsp_ff.mem_wr;
   assign rsp_mem_address   = rsp_ff.mem_addr;
   assign rsp_mem_data      = $signed(rsp_ff.mem_data);

   // ---------------- assertions ----------------
   `SIE_ASSERT_IMP(a_clr_empty, clr_busy_ff,
      !req_accept && !s1_v_ff && !s2_v_ff && !s3_v_ff && !s4_v_ff,
      "pipeline busy during data memory clear")
   `SIE_ASSERT_NXT(a_hazard_hold, s1_v_ff && s1_hazard,
      s1_v_ff && $stable(s1_op_ff) && !$past(s1_adv),
      "instruction left execute while waiting on load data")
   `SIE_ASSERT_NXT(a_commit_rec, commit,
      cw_v_ff && cw_idx_ff == $past(s4_ff.idx) && reg_valid_ff[cw_idx_ff],
      "committed register write not recorded")
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for small_isa_instruction_execute_core.
// Directed and random instruction streams are checked against an in-bench architectural model.
// Depends on sie_pkg and the core RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sie_pkg::*;

   localparam logic [OPC_W-1:0] OPC_SPARE  = 3'd7;
   localparam int unsigned      DATA_DEPTH = MEM_DEPTH_DEF;
   localparam int               TOTAL_ITEMS = 850;
   localparam int               IDLE_LIMIT = 4000;

   typedef struct packed {
      word_type                next_pc;
      logic                    branch_taken;
      logic                    reg_write;
      logic [REG_IDX_W-1:0]    written_index;
      word_type                written_value;
      logic                    mem_write;
      logic [MEM_ADDR_W-1:0]   mem_address;
      word_type                mem_data;
   } exec_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [OPC_W-1:0]              req_opcode = '0;
   logic [REG_IDX_W-1:0]          req_reg_x = '0;
   logic [REG_IDX_W-1:0]          req_reg_y = '0;
   logic [REG_IDX_W-1:0]          req_reg_z = '0;
   logic signed [IMM_W-1:0]       req_imm = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [WORD_W-1:0]             rsp_next_pc;
   logic                          rsp_branch_taken;
   logic                          rsp_reg_write;
   logic [REG_IDX_W-1:0]          rsp_written_index;
   logic signed [WORD_W-1:0]      rsp_written_value;
   logic                          rsp_mem_write;
   logic [MEM_ADDR_W-1:0]         rsp_mem_address;
   logic signed [WORD_W-1:0]      rsp_mem_data;

   // architectural state tracked alongside the core
   word_type         arch_regs [NUM_REGS];
   word_type         data_words [DATA_DEPTH];
   word_type         arch_pc;
   exec_result_type  pending_results [$];

   int            mismatches = 0;
   int            results_checked = 0;
   int            branches_seen = 0;
   int            total_sent = 0;
   int            op_count [8];
   int            burst_left = 0;
   int            idle_cycles = 0;
   logic [7:0]    stall_pattern = 8'h00;
   logic [4:0]    stall_tick = '0;

   small_isa_instruction_execute_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_reg_x         (req_reg_x),
      .req_reg_y         (req_reg_y),
      .req_reg_z         (req_reg_z),
      .req_imm           (req_imm),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_reg_write     (rsp_reg_write),
      .rsp_written_index (rsp_written_index),
      .rsp_written_value (rsp_written_value),
      .rsp_mem_write     (rsp_mem_write),
      .rsp_mem_address   (rsp_mem_address),
      .rsp_mem_data      (rsp_mem_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic exec_result_type execute_instr(input logic [OPC_W-1:0] op,
                                                     input logic [REG_IDX_W-1:0] rx,
                                                     input logic [REG_IDX_W-1:0] ry,
                                                     input logic [REG_IDX_W-1:0] rz,
                                                     input logic [IMM_W-1:0] imm);
      exec_result_type res;
      word_type        imm_ext;
      word_type        addr;
      res = '0;
      imm_ext = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
      addr = arch_regs[ry] + imm_ext;
      arch_pc = arch_pc + 1;
      case (op)
         OPC_ADD: begin
            res.reg_write = 1'b1;
            res.written_index = rx;
            res.written_value = arch_regs[ry] + arch_regs[rz];
         end
         OPC_NAND: begin
            res.reg_write = 1'b1;
            res.written_index = rx;
            res.written_value = ~(arch_regs[ry] & arch_regs[rz]);
         end
         OPC_ADDI: begin
            res.reg_write = 1'b1;
            res.written_index = rx;
            res.written_value = addr;
         end
         OPC_LW: begin
            res.mem_address = MEM_ADDR_W'(addr % DATA_DEPTH);
            res.mem_data = data_words[addr % DATA_DEPTH];
            res.reg_write = 1'b1;
            res.written_index = rx;
            res.written_value = res.mem_data;
         end
         OPC_SW: begin
            res.mem_write = 1'b1;
            res.mem_address = MEM_ADDR_W'(addr % DATA_DEPTH);
            res.mem_data = arch_regs[rx];
            data_words[addr % DATA_DEPTH] = arch_regs[rx];
         end
         OPC_BEQ: begin
            if (arch_regs[rx] == arch_regs[ry]) begin
               arch_pc = arch_pc + imm_ext;
               res.branch_taken = 1'b1;
            end
         end
         OPC_JALR: begin
            // link goes in first, so rx == ry jumps to the incremented pc
            res.reg_write = 1'b1;
            res.written_index = ry;
            res.written_value = arch_pc;
            arch_regs[ry] = arch_pc;
            arch_pc = arch_regs[rx];
            res.branch_taken = 1'b1;
         end
         default: ;
      endcase
      if (res.reg_write && op != OPC_JALR)
         arch_regs[rx] = res.written_value;
      res.next_pc = arch_pc;
      return res;
   endfunction

   // one transfer on the request channel; bursts and gaps are handled here
   task automatic issue_instr(input logic [OPC_W-1:0] op, input logic [REG_IDX_W-1:0] rx,
                              input logic [REG_IDX_W-1:0] ry, input logic [REG_IDX_W-1:0] rz,
                              input logic [IMM_W-1:0] imm);
      req_opcode <= op;
      req_reg_x <= rx;
      req_reg_y <= ry;
      req_reg_z <= rz;
      req_imm <= imm;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(execute_instr(op, rx, ry, rz, imm));
      op_count[op]++;
      total_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      exec_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t result with nothing outstanding, next_pc %h", $realtime,
                        rsp_next_pc);
         end else begin
            want = pending_results.pop_front();
            check_field("next_pc", want.next_pc, rsp_next_pc);
            check_field("branch_taken", WORD_W'(want.branch_taken),
                        WORD_W'(rsp_branch_taken));
            check_field("reg_write", WORD_W'(want.reg_write), WORD_W'(rsp_reg_write));
            check_field("written_index", WORD_W'(want.written_index),
                        WORD_W'(rsp_written_index));
            check_field("written_value", want.written_value, rsp_written_value);
            check_field("mem_write", WORD_W'(want.mem_write), WORD_W'(rsp_mem_write));
            check_field("mem_address", WORD_W'(want.mem_address),
                        WORD_W'(rsp_mem_address));
            check_field("mem_data", want.mem_data, rsp_mem_data);
            results_checked++;
            if (want.branch_taken) branches_seen++;
         end
      end
   end

   // receiver back-pressure: a rotating pattern, redrawn whenever stall_tick wraps to zero
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_pattern <= 8'h00;
         stall_tick <= '0;
      end else begin
         stall_tick <= stall_tick + 1'b1;
         if (stall_tick == '0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern <= 8'h00;
               1: stall_pattern <= 8'($urandom) & 8'hFE;
               2: stall_pattern <= 8'hFE;
               default: stall_pattern <= 8'h11;
            endcase
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
         end
         rsp_stall <= stall_pattern[0];
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%t no transfer for %0d cycles", $realtime, IDLE_LIMIT);
         $display("[small_isa_instruction_execute_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REG_IDX_W-1:0] pick_reg();
      // a small hot set makes back-to-back dependencies common
      return ($urandom_range(0, 1) == 0) ? REG_IDX_W'($urandom_range(0, 3))
                                         : REG_IDX_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [IMM_W-1:0] pick_offset();
      int delta;
      delta = $urandom_range(0, 63) - 32;
      return ($urandom_range(0, 3) == 0) ? IMM_W'($urandom) : IMM_W'(delta);
   endfunction

   task automatic test_alu_extremes();
      issue_instr(OPC_ADDI, 4'd1, 4'd0, 4'd0, 20'h7FFFF);
      issue_instr(OPC_ADDI, 4'd2, 4'd0, 4'd0, 20'h80000);
      issue_instr(OPC_ADD, 4'd3, 4'd1, 4'd2, 20'h00000);
      issue_instr(OPC_NAND, 4'd4, 4'd0, 4'd0, 20'hFFFFF);
      issue_instr(OPC_ADD, 4'd15, 4'd4, 4'd4, 20'h00000);
      issue_instr(OPC_NAND, 4'd5, 4'd15, 4'd4, 20'h00000);
      // register zero is an ordinary register
      issue_instr(OPC_ADDI, 4'd0, 4'd0, 4'd15, 20'h00005);
   endtask

   task automatic test_memory_access();
      // negative offset wraps to the top word
      issue_instr(OPC_SW, 4'd1, 4'd0, 4'd0, 20'hFFFFA);
      issue_instr(OPC_LW, 4'd6, 4'd0, 4'd0, 20'hFFFFA);
      issue_instr(OPC_ADD, 4'd7, 4'd6, 4'd6, 20'h00000);
      issue_instr(OPC_SW, 4'd2, 4'd15, 4'd0, 20'h00002);
      issue_instr(OPC_LW, 4'd8, 4'd15, 4'd0, 20'h00002);
      issue_instr(OPC_LW, 4'd9, 4'd8, 4'd0, 20'h7FFFF);
      issue_instr(OPC_NAND, 4'd10, 4'd9, 4'd8, 20'h00000);
      // never-written word reads back as cleared
      issue_instr(OPC_LW, 4'd11, 4'd0, 4'd0, 20'h001F4);
   endtask

   task automatic test_control_flow();
      issue_instr(OPC_BEQ, 4'd3, 4'd3, 4'd0, 20'h00003);
      issue_instr(OPC_BEQ, 4'd1, 4'd2, 4'd0, 20'h00005);
      issue_instr(OPC_BEQ, 4'd0, 4'd0, 4'd0, 20'h80000);
      issue_instr(OPC_JALR, 4'd5, 4'd12, 4'd0, 20'h00000);
      issue_instr(OPC_JALR, 4'd13, 4'd13, 4'd0, 20'h00000);
      issue_instr(OPC_SPARE, 4'd15, 4'd15, 4'd15, 20'hFFFFF);
   endtask

   task automatic test_random_program();
      logic [REG_IDX_W-1:0] ra;
      logic [REG_IDX_W-1:0] rb;
      logic [REG_IDX_W-1:0] rc;
      logic [IMM_W-1:0]     off;
      logic [OPC_W-1:0]     op;
      while (total_sent < TOTAL_ITEMS) begin
         ra = pick_reg();
         rb = pick_reg();
         rc = pick_reg();
         off = pick_offset();
         case ($urandom_range(0, 9)) inside
            0, 1, 2, 3: begin
               op = ($urandom_range(0, 49) == 0) ? OPC_SPARE : OPC_W'($urandom_range(0, 6));
               issue_instr(op, ra, rb, rc, off);
            end
            4, 5: begin
               // store then load back through the same base and offset
               issue_instr(OPC_SW, ra, rb, rc, off);
               issue_instr(OPC_LW, pick_reg(), rb, pick_reg(), off);
            end
            6, 7: begin
               // load followed at once by a consumer of the loaded register
               issue_instr(OPC_LW, ra, rb, rc, off);
               op = ($urandom_range(0, 1) == 0) ? OPC_ADD : OPC_NAND;
               issue_instr(op, pick_reg(), ra, ($urandom_range(0, 1) == 0) ? ra : rc,
                           pick_offset());
            end
            8: begin
               if ($urandom_range(0, 1) == 0) rb = ra;
               issue_instr(OPC_BEQ, ra, rb, rc, off);
            end
            default: issue_instr(OPC_JALR, ra, rb, rc, off);
         endcase
      end
   endtask

   initial begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (data_words[i]) data_words[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;
      arch_pc = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_alu_extremes();
      test_memory_access();
      test_control_flow();
      test_random_program();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      mismatches += pending_results.size();
      $display("%0d instructions sent, %0d results checked, %0d taken branches or jumps",
               total_sent, results_checked, branches_seen);
      $display("mix: add %0d nand %0d addi %0d lw %0d sw %0d beq %0d jalr %0d spare %0d",
               op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
               op_count[5], op_count[6], op_count[7]);
      if (mismatches == 0)
         $display("[small_isa_instruction_execute_core] OK");
      else
         $display("[small_isa_instruction_execute_core] ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sie_pkg.sv
hw/rtl/sie_ram.sv
hw/rtl/sie_wrap.sv
hw/rtl/small_isa_instruction_execute_core.sv
tb/testbench.sv
